@@ rtl/nrdiv_pkg.sv @@
// nrdiv_pkg: shared port width constant and the result type of the non-restoring divider
// no dependencies; imported by nonrestoring_divider and tb
`default_nettype none

package nrdiv_pkg;

    // width of the dividend, divisor, quotient and remainder ports
    localparam int FieldW = 32;

    typedef struct packed {
        logic [FieldW-1:0] quotient;
        logic [FieldW-1:0] remainder;
        logic              divide_by_zero;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/nonrestoring_divider.sv @@
// nonrestoring_divider: pipelined unsigned non-restoring divider, one quotient bit per stage
// depends on nrdiv_pkg for the port width and the result type
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | to block  | i_valid / o_stall    | i_dividend, i_divisor
//  out     | from block| o_valid / i_stall    | o_quotient, o_remainder, o_divide_by_zero
//
//  an item can enter every cycle while o_stall is low; it passes the input register,
//  WIDTH add/subtract stages, the correction and the output register
//  each stage holds one (WIDTH+1)-bit add/subtract, which sets the clock
//  reset clears only the valid bits of the stages, the output and the skid register
//  an output stall parks one item in the skid register; o_stall is that
//  register's full flag, and the whole pipeline holds while it is set

module nonrestoring_divider #(
    parameter int WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nrdiv_pkg::FieldW-1:0]  i_dividend,
    input  logic [nrdiv_pkg::FieldW-1:0]  i_divisor,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nrdiv_pkg::FieldW-1:0]  o_quotient,
    output logic [nrdiv_pkg::FieldW-1:0]  o_remainder,
    output logic                          o_divide_by_zero
);
    import nrdiv_pkg::*;

    // bits shared by the port width and the datapath width
    localparam int NarrowW = (WIDTH < FieldW) ? WIDTH : FieldW;

    // stage 0 is the input register, stage k holds the state after k steps
    logic [WIDTH:0]   r_v;
    logic [WIDTH:0]   r_a [0:WIDTH];
    logic [WIDTH-1:0] r_q [0:WIDTH];
    logic [WIDTH-1:0] r_d [0:WIDTH];

    logic [WIDTH:0]   n_a [1:WIDTH];
    logic [WIDTH-1:0] n_q [1:WIDTH];

    logic             w_en;
    logic [WIDTH-1:0] w_dividend;
    logic [WIDTH-1:0] w_divisor;
    logic [WIDTH:0]   w_fixed;
    t_result          n_res;

    t_result          r_out;
    logic             r_out_v;
    t_result          r_skid;
    logic             r_skid_v;

    assign w_en       = !r_skid_v;
    assign o_stall    = r_skid_v;
    assign w_dividend = WIDTH'(i_dividend[NarrowW-1:0]);
    assign w_divisor  = WIDTH'(i_divisor[NarrowW-1:0]);

    // one non-restoring step per stage
    always_comb begin
        logic [WIDTH:0] sh;
        for (int k = 1; k <= WIDTH; k++) begin
            sh = {r_a[k-1][WIDTH-1:0], r_q[k-1][WIDTH-1]};
            if (r_a[k-1][WIDTH]) begin
                n_a[k] = sh + {1'b0, r_d[k-1]};
            end else begin
                n_a[k] = sh - {1'b0, r_d[k-1]};
            end
            n_q[k] = {r_q[k-1][WIDTH-2:0], ~n_a[k][WIDTH]};
        end
    end

    // add the divisor back when the final remainder is negative
    always_comb begin
        if (r_a[WIDTH][WIDTH]) begin
            w_fixed = r_a[WIDTH] + {1'b0, r_d[WIDTH]};
        end else begin
            w_fixed = r_a[WIDTH];
        end
        n_res.quotient       = FieldW'(r_q[WIDTH][NarrowW-1:0]);
        n_res.remainder      = FieldW'(w_fixed[NarrowW-1:0]);
        n_res.divide_by_zero = (r_d[WIDTH] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[WIDTH-1:0], i_valid};
        end
        if (w_en) begin
            r_a[0] <= '0;
            r_q[0] <= w_dividend;
            r_d[0] <= w_divisor;
            for (int k = 1; k <= WIDTH; k++) begin
                r_a[k] <= n_a[k];
                r_q[k] <= n_q[k];
                r_d[k] <= r_d[k-1];
            end
        end
    end

    // output register with a one-item skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (!i_stall) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end
            end else if (r_v[WIDTH]) begin
                if (!r_out_v || !i_stall) begin
                    r_out   <= n_res;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= n_res;
                    r_skid_v <= 1'b1;
                end
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_v;
    assign o_quotient       = r_out.quotient;
    assign o_remainder      = r_out.remainder;
    assign o_divide_by_zero = r_out.divide_by_zero;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// tb: self-checking testbench for the pipelined non-restoring divider, random and directed items
// depends on nrdiv_pkg and nonrestoring_divider; the expected results come from a bit-level predictor

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrdiv_pkg::*;

    localparam int DivW      = FieldW;
    localparam int QuietMax  = 4000;
    localparam int RandItems = 800;

    typedef struct {
        logic [FieldW-1:0] dividend;
        logic [FieldW-1:0] divisor;
        bit                drain_first;
    } t_div_job;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [FieldW-1:0] i_dividend = '0;
    logic [FieldW-1:0] i_divisor = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [FieldW-1:0] o_quotient;
    logic [FieldW-1:0] o_remainder;
    logic              o_divide_by_zero;

    t_div_job div_jobs[$];
    t_result  results_due[$];
    int       n_issued = 0;
    int       n_retired = 0;
    int       n_mismatch = 0;
    int       quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    nonrestoring_divider #(.WIDTH(DivW)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // shift-and-add/subtract on a (DivW+1)-bit two's complement partial remainder
    function automatic t_result divide_nonrestoring(input logic [FieldW-1:0] num,
                                                    input logic [FieldW-1:0] den);
        logic [DivW:0]   part;
        logic [DivW-1:0] quo;
        logic [DivW-1:0] dvs;
        logic            was_neg;
        t_result         res;
        part = '0;
        quo  = num[DivW-1:0];
        dvs  = den[DivW-1:0];
        for (int k = 0; k < DivW; k++) begin
            was_neg = part[DivW];
            part    = {part[DivW-1:0], quo[DivW-1]};
            quo     = quo << 1;
            if (was_neg) begin
                part = part + {1'b0, dvs};
            end else begin
                part = part - {1'b0, dvs};
            end
            quo[0] = ~part[DivW];
        end
        // final add-back leaves the remainder non-negative
        if (part[DivW]) begin
            part = part + {1'b0, dvs};
        end
        res.quotient       = quo;
        res.remainder      = part[DivW-1:0];
        res.divide_by_zero = (dvs == '0);
        return res;
    endfunction

    task automatic add_job(input logic [FieldW-1:0] num, input logic [FieldW-1:0] den,
                           input bit drain_first);
        t_div_job job;
        job.dividend    = num;
        job.divisor     = den;
        job.drain_first = drain_first;
        div_jobs.push_back(job);
    endtask

    // driver
    always @(posedge i_clk) begin
        logic fire;
        logic idle;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && !o_stall;
            if (fire) begin
                results_due.push_back(divide_nonrestoring(i_dividend, i_divisor));
                n_issued++;
            end
            if (fire || !i_valid) begin
                // no idling for a stretch in the middle of the run
                idle = !(n_issued >= 350 && n_issued < 550) && ($urandom_range(0, 99) < 27);
                if (div_jobs.size() != 0 && !idle &&
                    (!div_jobs[0].drain_first || results_due.size() == 0)) begin
                    i_dividend <= div_jobs[0].dividend;
                    i_divisor  <= div_jobs[0].divisor;
                    i_valid    <= 1'b1;
                    void'(div_jobs.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_retired++;
                if (results_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("result with no item outstanding: q=%h r=%h dbz=%b",
                                 o_quotient, o_remainder, o_divide_by_zero);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (o_quotient !== want.quotient || o_remainder !== want.remainder ||
                        o_divide_by_zero !== want.divide_by_zero) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("mismatch on result %0d: q=%h r=%h dbz=%b, expected q=%h r=%h dbz=%b",
                                     n_retired, o_quotient, o_remainder, o_divide_by_zero,
                                     want.quotient, want.remainder, want.divide_by_zero);
                        end
                    end
                end
            end
            i_stall <= !(n_retired >= 300 && n_retired < 520) && ($urandom_range(0, 99) < 27);
        end
    end

    // watchdog: cycles with work outstanding but no item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else if (i_valid || div_jobs.size() != 0 || results_due.size() != 0) begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= QuietMax) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [FieldW-1:0] num;
        logic [FieldW-1:0] den;
        logic [FieldW-1:0] ones;
        ones = '1;

        // zero divisor, divisor above dividend, top bits set, equal operands
        add_job('0, '0, 1'b0);
        add_job(ones, '0, 1'b0);
        add_job(32'h1234_5678, '0, 1'b0);
        add_job('0, 32'd1, 1'b0);
        add_job(ones, 32'd1, 1'b0);
        add_job(ones, ones, 1'b0);
        add_job('0, ones, 1'b0);
        add_job(32'd1, ones, 1'b0);
        add_job(ones - 1, ones, 1'b0);
        add_job(ones, 32'd2, 1'b0);
        add_job(32'd1, 32'd1, 1'b0);
        add_job(32'h8000_0000, 32'd1, 1'b0);
        add_job(32'h8000_0000, 32'h8000_0000, 1'b0);
        add_job(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        add_job(ones, 32'h8000_0001, 1'b0);
        add_job(32'd5, 32'd3, 1'b0);
        add_job(32'd100, 32'd7, 1'b0);
        add_job(32'hdead_beef, 32'h0000_1234, 1'b0);
        add_job(32'h5555_5555, 32'haaaa_aaaa, 1'b0);
        add_job(32'haaaa_aaaa, 32'h5555_5555, 1'b0);
        add_job(32'hffff_0000, 32'h0000_ffff, 1'b0);

        for (int n = 0; n < RandItems; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                num = $urandom >> $urandom_range(0, 31);
            end else begin
                num = $urandom;
            end
            case ($urandom_range(0, 9))
                0:       den = '0;
                1:       den = $urandom_range(1, 15);
                2:       den = num;
                3:       den = $urandom | 32'h8000_0000;
                default: den = $urandom >> $urandom_range(0, 31);
            endcase
            // first random item and one in the middle wait for the pipeline to empty
            add_job(num, den, (n == 0) || (n == RandItems / 2));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (div_jobs.size() != 0 || i_valid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DivW + 8) @(posedge i_clk);

        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
